@@ design/cpvm_pkg.sv @@
// ----------------------------------------------------------------------------
// cpvm_pkg
// Shared widths, limits, register indexes and sequencer types for the
// cascaded position/velocity servo.
// ----------------------------------------------------------------------------
package cpvm_pkg;

	// encoder counter width
	localparam int POS_W = 32;
	localparam int TGT_W = 32;

	// position error is exact: one bit over the wider of target and counter
	localparam int ERR_W = ((POS_W > TGT_W) ? POS_W : TGT_W) + 1;

	localparam int GAIN_W  = 16;
	localparam int RATE_W  = 16;
	localparam int DRV_W   = 24;
	localparam int DUTY_W  = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 24;

	// shared multiplier operand and product widths
	localparam int MUL_A_W = ERR_W;
	localparam int MUL_B_W = DRV_W;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	// saturation compares run at least 64 bits wide
	localparam int SAT_W = (PROD_W > 64) ? PROD_W : 64;
	localparam int SPD_W = 64;

	localparam logic [SAT_W-1:0] REF_LIMIT  = (SAT_W'(1) << 62) - SAT_W'(1);
	localparam logic [SAT_W-1:0] MEAS_LIMIT = (SAT_W'(1) << 54) - SAT_W'(1);
	localparam logic [DUTY_W-1:0] DUTY_MAX = '1;

	localparam logic [GAIN_W-1:0] POSITION_GAIN_RST = 16'd3287;
	localparam logic [RATE_W-1:0] RATE_FACTOR_RST   = 16'd800;
	localparam logic [DRV_W-1:0]  DRIVE_GAIN_RST    = 24'd30715;

	localparam logic [CFG_IDX_W-1:0] REG_POSITION_GAIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_FACTOR   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_GAIN    = 2'd2;

	localparam logic OP_ENCODER = 1'b0;
	localparam logic OP_SAMPLE  = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ERR,
		S_MREF,
		S_MMEAS,
		S_SPD,
		S_ABS,
		S_MDRV,
		S_OUT
	} state_t;

	typedef enum logic [1:0] {
		MS_REF,
		MS_MEAS,
		MS_DRV
	} mul_sel_t;

	typedef struct packed {
		logic     load_err;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     ld_ref;
		logic     ld_spd;
		logic     ld_abs;
		logic     ld_flags;
		logic     ld_out;
	} ctl_t;

endpackage

@@ design/cpvm_mul.sv @@
// ----------------------------------------------------------------------------
// cpvm_mul
// Shared unsigned multiplier with a registered product, reused for the
// speed reference, the measured speed and the drive scaling.
// ----------------------------------------------------------------------------
module cpvm_mul (
	input  logic                         clk,
	input  logic                         en,
	input  logic [cpvm_pkg::MUL_A_W-1:0] a,
	input  logic [cpvm_pkg::MUL_B_W-1:0] b,
	output logic [cpvm_pkg::PROD_W-1:0]  p_q
);

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= cpvm_pkg::PROD_W'(a) * cpvm_pkg::PROD_W'(b);
		end
	end

endmodule

@@ design/cpvm_seq.sv @@
// ----------------------------------------------------------------------------
// cpvm_seq
// Sequencer that walks one sample through the shared multiplier and the
// add/compare steps, then holds until the result register is free.
// ----------------------------------------------------------------------------
module cpvm_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_fire,
	input  logic                 in_op,
	input  logic                 out_free,
	output logic                 in_ready,
	output cpvm_pkg::ctl_t       ctl
);

	cpvm_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cpvm_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		ctl          = '0;
		ctl.mul_sel  = cpvm_pkg::MS_REF;
		in_ready     = 1'b0;
		case (state_q)
			cpvm_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_fire && (in_op == cpvm_pkg::OP_SAMPLE)) begin
					state_d = cpvm_pkg::S_ERR;
				end
			end
			cpvm_pkg::S_ERR: begin
				ctl.load_err = 1'b1;
				state_d      = cpvm_pkg::S_MREF;
			end
			cpvm_pkg::S_MREF: begin
				ctl.mul_en  = 1'b1;
				ctl.mul_sel = cpvm_pkg::MS_REF;
				state_d     = cpvm_pkg::S_MMEAS;
			end
			cpvm_pkg::S_MMEAS: begin
				// reference product is captured while the speed product starts
				ctl.ld_ref  = 1'b1;
				ctl.mul_en  = 1'b1;
				ctl.mul_sel = cpvm_pkg::MS_MEAS;
				state_d     = cpvm_pkg::S_SPD;
			end
			cpvm_pkg::S_SPD: begin
				ctl.ld_spd = 1'b1;
				state_d    = cpvm_pkg::S_ABS;
			end
			cpvm_pkg::S_ABS: begin
				ctl.ld_abs = 1'b1;
				state_d    = cpvm_pkg::S_MDRV;
			end
			cpvm_pkg::S_MDRV: begin
				ctl.ld_flags = 1'b1;
				ctl.mul_en   = 1'b1;
				ctl.mul_sel  = cpvm_pkg::MS_DRV;
				state_d      = cpvm_pkg::S_OUT;
			end
			cpvm_pkg::S_OUT: begin
				if (out_free) begin
					ctl.ld_out = 1'b1;
					state_d    = cpvm_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = cpvm_pkg::S_IDLE;
			end
		endcase
	end

endmodule

@@ design/cascaded_position_velocity_motor_control_top.sv @@
// ----------------------------------------------------------------------------
// cascaded_position_velocity_motor_control_top
// Encoder-count position servo: proportional position loop feeding a
// proportional speed loop, one duty result per sample beat.
// ----------------------------------------------------------------------------
//  channel | signals                                  | dir | beat
//  --------+------------------------------------------+-----+------------------
//  in      | in_valid in_ready op b_level             | in  | encoder edge or
//          | target_position                          |     | sample tick
//  out     | out_valid out_ready duty turn_left       | out | one per sample
//          | duty_clipped                             |     |
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data   | in  | register write
//
//  An encoder beat is absorbed in the cycle it is accepted; in_ready stays high.
//  A sample beat makes three passes through the one shared multiplier plus the
//  add and magnitude steps before it reaches out_valid; the next beat is taken
//  once the sequencer is back in its idle state.
//  in_ready is low while a sample is in flight; a finished result waits in the
//  output register, and the sequencer holds in its last step until it is free.
//  Reset clears the counter, the last-sample position and loads default gains.
// ----------------------------------------------------------------------------
module cascaded_position_velocity_motor_control_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            op,
	input  logic                            b_level,
	input  logic signed [cpvm_pkg::TGT_W-1:0] target_position,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [cpvm_pkg::DUTY_W-1:0]     duty,
	output logic                            turn_left,
	output logic                            duty_clipped,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cpvm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cpvm_pkg::CFG_DAT_W-1:0]  cfg_data
);

	localparam int POS_W  = cpvm_pkg::POS_W;
	localparam int ERR_W  = cpvm_pkg::ERR_W;
	localparam int SAT_W  = cpvm_pkg::SAT_W;
	localparam int SPD_W  = cpvm_pkg::SPD_W;
	localparam int PROD_W = cpvm_pkg::PROD_W;

	logic [cpvm_pkg::GAIN_W-1:0] position_gain_q;
	logic [cpvm_pkg::RATE_W-1:0] rate_factor_q;
	logic [cpvm_pkg::DRV_W-1:0]  drive_gain_q;

	logic [POS_W-1:0] position_count_q;
	logic [POS_W-1:0] previous_position_q;

	logic [cpvm_pkg::TGT_W-1:0] tgt_q;
	logic [ERR_W-1:0]  emag_q;
	logic              err_neg_q;
	logic [POS_W-1:0]  dmag_q;
	logic              delta_neg_q;
	logic signed [SPD_W-1:0] ref_q;
	logic signed [SPD_W-1:0] spd_q;
	logic [SPD_W-1:0]  smag_q;
	logic              big_q;
	logic              left_q;
	logic              zero_q;

	logic              out_valid_q;
	logic [cpvm_pkg::DUTY_W-1:0] duty_q;
	logic              turn_left_q;
	logic              duty_clipped_q;

	logic              in_fire;
	logic              out_free;
	cpvm_pkg::ctl_t    ctl;

	logic [cpvm_pkg::MUL_A_W-1:0] mul_a;
	logic [cpvm_pkg::MUL_B_W-1:0] mul_b;
	logic [PROD_W-1:0]            prod;

	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;

	cpvm_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.in_op    (op),
		.out_free (out_free),
		.in_ready (in_ready),
		.ctl      (ctl)
	);

	always_comb begin
		mul_a = emag_q;
		mul_b = cpvm_pkg::MUL_B_W'(position_gain_q);
		case (ctl.mul_sel)
			cpvm_pkg::MS_REF: begin
				mul_a = emag_q;
				mul_b = cpvm_pkg::MUL_B_W'(position_gain_q);
			end
			cpvm_pkg::MS_MEAS: begin
				mul_a = cpvm_pkg::MUL_A_W'(dmag_q);
				mul_b = cpvm_pkg::MUL_B_W'(rate_factor_q);
			end
			cpvm_pkg::MS_DRV: begin
				mul_a = cpvm_pkg::MUL_A_W'(smag_q[31:0]);
				mul_b = drive_gain_q;
			end
			default: begin
				mul_a = emag_q;
				mul_b = cpvm_pkg::MUL_B_W'(position_gain_q);
			end
		endcase
	end

	cpvm_mul u_mul (
		.clk (clk),
		.en  (ctl.mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_gain_q <= cpvm_pkg::POSITION_GAIN_RST;
			rate_factor_q   <= cpvm_pkg::RATE_FACTOR_RST;
			drive_gain_q    <= cpvm_pkg::DRIVE_GAIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				cpvm_pkg::REG_POSITION_GAIN: begin
					position_gain_q <= cfg_data[cpvm_pkg::GAIN_W-1:0];
				end
				cpvm_pkg::REG_RATE_FACTOR: begin
					rate_factor_q <= cfg_data[cpvm_pkg::RATE_W-1:0];
				end
				cpvm_pkg::REG_DRIVE_GAIN: begin
					drive_gain_q <= cfg_data[cpvm_pkg::DRV_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// encoder counter and last-sample position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_count_q    <= '0;
			previous_position_q <= '0;
		end else begin
			if (in_fire && (op == cpvm_pkg::OP_ENCODER)) begin
				if (b_level) begin
					position_count_q <= position_count_q + POS_W'(1);
				end else begin
					position_count_q <= position_count_q - POS_W'(1);
				end
			end
			if (ctl.load_err) begin
				previous_position_q <= position_count_q;
			end
		end
	end

	// position error and count change, both as sign and magnitude
	logic signed [ERR_W-1:0] err;
	logic [POS_W-1:0]        delta;

	assign err   = ERR_W'(signed'(tgt_q)) - ERR_W'(signed'(position_count_q));
	assign delta = position_count_q - previous_position_q;

	// saturated reference and measured speed from the shared product
	logic [SAT_W-1:0] prod_ext;
	logic [61:0]      rmag;
	logic [53:0]      mmag;
	logic [SPD_W-1:0] meas_q8;

	assign prod_ext = SAT_W'(prod);
	assign rmag     = (prod_ext > cpvm_pkg::REF_LIMIT) ? cpvm_pkg::REF_LIMIT[61:0]
	                                                   : prod_ext[61:0];
	assign mmag     = (prod_ext > cpvm_pkg::MEAS_LIMIT) ? cpvm_pkg::MEAS_LIMIT[53:0]
	                                                    : prod_ext[53:0];
	assign meas_q8  = {2'b00, mmag, 8'h00};

	logic [PROD_W-17:0] duty_raw;
	assign duty_raw = prod[PROD_W-1:16];

	always_ff @(posedge clk) begin
		if (in_fire && (op == cpvm_pkg::OP_SAMPLE)) begin
			tgt_q <= target_position;
		end
		if (ctl.load_err) begin
			err_neg_q   <= err[ERR_W-1];
			emag_q      <= err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
			delta_neg_q <= delta[POS_W-1];
			dmag_q      <= delta[POS_W-1] ? (POS_W'(0) - delta) : delta;
		end
		if (ctl.ld_ref) begin
			ref_q <= err_neg_q ? -signed'({2'b00, rmag}) : signed'({2'b00, rmag});
		end
		if (ctl.ld_spd) begin
			// subtracting a negative measurement is an add
			spd_q <= delta_neg_q ? (ref_q + signed'(meas_q8)) : (ref_q - signed'(meas_q8));
		end
		if (ctl.ld_abs) begin
			smag_q <= spd_q[SPD_W-1] ? SPD_W'(-spd_q) : SPD_W'(spd_q);
		end
		if (ctl.ld_flags) begin
			big_q  <= (smag_q[SPD_W-1:32] != '0);
			zero_q <= (drive_gain_q == '0);
			left_q <= !spd_q[SPD_W-1] && (spd_q != '0) && (drive_gain_q != '0);
		end
		if (ctl.ld_out) begin
			turn_left_q <= left_q;
			if (zero_q) begin
				duty_q         <= '0;
				duty_clipped_q <= 1'b0;
			end else if (big_q || (duty_raw > (PROD_W-16)'(cpvm_pkg::DUTY_MAX))) begin
				duty_q         <= cpvm_pkg::DUTY_MAX;
				duty_clipped_q <= 1'b1;
			end else begin
				duty_q         <= duty_raw[cpvm_pkg::DUTY_W-1:0];
				duty_clipped_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.ld_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign duty         = duty_q;
	assign turn_left    = turn_left_q;
	assign duty_clipped = duty_clipped_q;

endmodule
